>>> hw/rtl/kmce_pkg.sv
`default_nettype none

package kmce_pkg;

    localparam int LEVEL_BITS      = 16;
    localparam int ROW_BITS        = 4;
    localparam int INDEX_BITS      = 9;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_MAX_ROWS    = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COLUMN_COUNT  = 2'd0,
        CFG_ROW_COUNT     = 2'd1,
        CFG_INDEX_BASE    = 2'd2,
        CFG_EVENTS_ENABLE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [LEVEL_BITS-1:0] column_levels;
    } t_in;

    typedef struct packed {
        logic [INDEX_BITS-1:0] key_index;
        logic                  pressed;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_cfg_wr;

    // one row's worth of work handed from front to back
    typedef struct packed {
        logic [INDEX_BITS-1:0] row_base;
        logic [LEVEL_BITS-1:0] now_down;
        logic [LEVEL_BITS-1:0] changed;
    } t_job;

endpackage

`default_nettype wire

>>> hw/rtl/key_matrix_change_events_unit.sv
// Channel   Dir  Handshake                Payload
// -------   ---  -----------------------  ---------------------------------
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
// item      in   push/full                i_in (row, column_levels)
// event     out  empty/pop                o_out (key_index, pressed, last)
//
// The front takes one row per cycle while the job queue has room; a row
// with no events to report finishes in that cycle.
// The back loads a job, then emits one event per changed key while the event
// output has room; it loads the next job only after the row's last event.
// Key state sits in flip-flops cleared by reset; no sweep follows reset.
// A stalled event output holds the back, which fills the queue, raising full.
`default_nettype none

module key_matrix_change_events_unit
    import kmce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire t_in                       i_in,
    output logic                           empty,
    input  wire logic                      pop,
    output t_out                           o_out
);

    t_cfg_wr cfg_wr;
    t_job    front_job;
    t_job    queue_job;
    logic    job_push;
    logic    job_pop;
    logic    queue_full;
    logic    queue_empty;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    kmce_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg        (cfg_wr),
        .i_push       (push),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_full       (full),
        .o_job_push   (job_push),
        .o_job        (front_job)
    );

    kmce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_job   (queue_job)
    );

    kmce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (queue_empty),
        .i_job       (queue_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/kmce_front.sv
`default_nettype none

module kmce_front
    import kmce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_push,
    input  wire t_in     i_in,
    input  wire logic    i_queue_full,
    output logic         o_full,
    output logic         o_job_push,
    output t_job         o_job
);

    localparam int ACT_MAX    = (MAX_COLUMNS < LEVEL_BITS) ? MAX_COLUMNS : LEVEL_BITS;
    localparam int STORE_ROWS = (MAX_ROWS < (1 << ROW_BITS)) ? MAX_ROWS : (1 << ROW_BITS);
    localparam int RIW        = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

    logic [4:0] r_col_count;
    logic [4:0] r_row_count;
    logic [7:0] r_index_base;
    logic       r_events_en;

    logic [LEVEL_BITS-1:0] r_store [STORE_ROWS];

    logic                  accept;
    logic                  row_ok;
    logic [4:0]            cols;
    logic [LEVEL_BITS-1:0] mask;
    logic [LEVEL_BITS-1:0] stored;
    logic [LEVEL_BITS-1:0] now_down;
    logic [LEVEL_BITS-1:0] changed;
    logic [RIW-1:0]        ridx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count  <= 5'd16;
            r_row_count  <= 5'd16;
            r_index_base <= 8'd0;
            r_events_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_COLUMN_COUNT:  r_col_count  <= i_cfg.data[4:0];
                CFG_ROW_COUNT:     r_row_count  <= i_cfg.data[4:0];
                CFG_INDEX_BASE:    r_index_base <= i_cfg.data;
                CFG_EVENTS_ENABLE: r_events_en  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign ridx   = i_in.row[RIW-1:0];
    assign accept = i_push && !i_queue_full;
    assign row_ok = ({1'b0, i_in.row} < r_row_count) && (32'(i_in.row) < MAX_ROWS);
    assign cols   = (32'(r_col_count) > ACT_MAX) ? 5'(ACT_MAX) : r_col_count;
    assign stored = r_store[ridx];

    always_comb begin
        for (int c = 0; c < LEVEL_BITS; c++) begin
            mask[c] = (5'(c) < cols);
        end
    end

    assign now_down = ~i_in.column_levels & mask;
    assign changed  = (now_down ^ stored) & mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < STORE_ROWS; r++) begin
                r_store[r] <= '0;
            end
        end else if (accept && row_ok) begin
            r_store[ridx] <= now_down;
        end
    end

    assign o_full          = i_queue_full;
    assign o_job_push      = accept && row_ok && r_events_en && (changed != '0);
    assign o_job.row_base  = 9'({1'b0, r_index_base}) + 9'({5'b0, i_in.row} * {4'b0, cols});
    assign o_job.now_down  = now_down;
    assign o_job.changed   = changed;

endmodule

`default_nettype wire

>>> hw/rtl/kmce_queue.sv
`default_nettype none

module kmce_queue
    import kmce_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (32'(r_cnt) == QUEUE_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == QUEUE_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == QUEUE_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/kmce_back.sv
`default_nettype none

module kmce_back
    import kmce_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_empty,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out      o_out
);

    logic                  r_busy;
    logic [LEVEL_BITS-1:0] r_mask;
    logic [LEVEL_BITS-1:0] r_down;
    logic [INDEX_BITS-1:0] r_base;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  slot_free;
    logic                  emit;
    logic [LEVEL_BITS-1:0] lowbit;
    logic [LEVEL_BITS-1:0] rest;
    logic [3:0]            col;

    assign slot_free = !r_out_valid || i_pop;
    assign emit      = r_busy && slot_free;
    assign o_job_pop = !r_busy && !i_job_empty;

    // isolate the lowest pending column, then encode it
    assign lowbit = r_mask & (~r_mask + 1'b1);
    assign rest   = r_mask & ~lowbit;

    always_comb begin
        col = '0;
        for (int c = 0; c < LEVEL_BITS; c++) begin
            col = col | (lowbit[c] ? 4'(c) : 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_job_pop) begin
            r_busy <= 1'b1;
        end else if (emit && (rest == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_mask <= i_job.changed;
            r_down <= i_job.now_down;
            r_base <= i_job.row_base;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.key_index <= r_base + {5'b0, col};
            r_out.pressed   <= |(r_down & lowbit);
            r_out.last      <= (rest == '0);
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("back busy with no pending column");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (rest == '0)) |=> (!r_busy && r_out_valid && r_out.last))
        else $error("final event did not close the row");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (!r_busy && !i_job_empty))
        else $error("job taken while back busy or queue empty");

    a_emit_clears_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_job_pop) |=> ($countones(r_mask) == $countones($past(r_mask)) - 1))
        else $error("emit did not retire exactly one column");

endmodule

`default_nettype wire

>>> verif/key_matrix_change_events_unit_test.sv
`timescale 1ns / 100ps

module key_matrix_change_events_unit_test
    import kmce_pkg::*;
();

    // Tracks the pressed state of every key and the events that the block owes.
    class key_change_tracker;
        logic [LEVEL_BITS-1:0] key_down [16];
        logic [4:0]            column_count;
        logic [4:0]            row_count;
        logic [7:0]            index_base;
        logic                  events_enable;
        t_out                  pending_events [$];
        int                    errors;

        function new();
            foreach (key_down[r]) key_down[r] = '0;
            column_count  = 5'd16;
            row_count     = 5'd16;
            index_base    = 8'd0;
            events_enable = 1'b0;
            errors        = 0;
        endfunction

        function void apply_register(t_cfg_index idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_COLUMN_COUNT: begin
                    column_count = data[4:0];
                end
                CFG_ROW_COUNT: begin
                    row_count = data[4:0];
                end
                CFG_INDEX_BASE: begin
                    index_base = data;
                end
                CFG_EVENTS_ENABLE: begin
                    events_enable = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        function void take_row(t_in item);
            int unsigned           cols;
            logic [LEVEL_BITS-1:0] mask;
            logic [LEVEL_BITS-1:0] now_down;
            logic [LEVEL_BITS-1:0] changed;
            t_out                  ev;
            int                    n;
            if (item.row >= row_count) return;
            cols     = (column_count > 16) ? 16 : column_count;
            mask     = 16'((17'd1 << cols) - 17'd1);
            now_down = ~item.column_levels & mask;
            changed  = (now_down ^ key_down[item.row]) & mask;
            // columns outside the active count are stored as released
            key_down[item.row] = now_down;
            if (!events_enable) return;
            n = 0;
            for (int c = 0; c < cols; c++) begin
                if (changed[c]) begin
                    ev.key_index = 9'(index_base + item.row * cols + c);
                    ev.pressed   = now_down[c];
                    ev.last      = 1'b0;
                    pending_events.push_back(ev);
                    n++;
                end
            end
            if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
        endfunction

        function void match_event(t_out got);
            t_out want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event, expected none, %s=%0d pressed=%0b last=%0b",
                         $time, "got key_index", got.key_index, got.pressed, got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.key_index !== want.key_index) begin
                errors++;
                $display("%0t: key_index expected %0d, got %0d",
                         $time, want.key_index, got.key_index);
            end
            if (got.pressed !== want.pressed) begin
                errors++;
                $display("%0t: pressed expected %0b, got %0b (key_index %0d)",
                         $time, want.pressed, got.pressed, want.key_index);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b, got %0b (key_index %0d)",
                         $time, want.last, got.last, want.key_index);
            end
        endfunction

        function int pending();
            return pending_events.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      push;
    logic                      full;
    t_in                       i_in;
    logic                      empty;
    logic                      pop;
    t_out                      o_out;

    key_change_tracker tracker = new();
    int                send_idle = 20;
    int                recv_idle = 81;

    key_matrix_change_events_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // event side: check each popped event, then pick the next pop level
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) tracker.match_event(o_out);
        pop <= ($urandom_range(99) >= recv_idle);
    end

    task automatic set_register(t_cfg_index idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_row(logic [ROW_BITS-1:0] row, logic [LEVEL_BITS-1:0] levels);
        t_in item;
        item.row           = row;
        item.column_levels = levels;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (full);
        // row request accepted at this edge
        tracker.take_row(item);
    endtask

    // hold off new rows until every owed event is out, plus the back's latency
    task automatic settle();
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic scan_rows(int count);
        int                    used_rows;
        int                    rmax;
        int                    mode;
        logic [ROW_BITS-1:0]   row;
        logic [LEVEL_BITS-1:0] levels;
        used_rows = 0;
        rmax = (tracker.row_count > 16) ? 15 : tracker.row_count - 1;
        while (used_rows < count) begin
            row  = ($urandom_range(99) < 90) ? 4'($urandom_range(rmax)) : 4'($urandom_range(15));
            mode = $urandom_range(9);
            if (mode < 6) begin
                // typical scan: mostly released, a few keys down
                levels = 16'hFFFF;
                repeat ($urandom_range(3)) levels[$urandom_range(15)] = 1'b0;
            end else if (mode < 8) begin
                levels = 16'($urandom);
            end else if (mode == 8) begin
                levels = 16'h0000;
            end else begin
                levels = 16'hFFFF;
            end
            send_row(row, levels);
            if (row < tracker.row_count) used_rows++;
        end
    endtask

    initial begin
        int col_set  [6];
        int row_set  [6];
        int base_set [6];
        int idx_base;

        col_set  = '{16, 1, 5, 31, 9, 12};
        row_set  = '{16, 16, 8, 16, 1, 12};
        base_set = '{0, 255, 37, 255, 200, 0};

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_data  <= '0;
        push        <= 1'b0;
        i_in        <= '0;
        pop         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // events off at reset: store updates silently
        send_row(4'd0, 16'h0000);
        settle();
        set_register(CFG_EVENTS_ENABLE, 8'd1);
        send_row(4'd0, 16'hFFFF);
        send_row(4'd0, 16'h5555);
        send_row(4'd0, 16'h5555);
        send_row(4'd15, 16'h0000);
        settle();
        set_register(CFG_INDEX_BASE, 8'hFF);
        send_row(4'd15, 16'hFFFF);
        send_row(4'd3, 16'h0000);
        settle();
        // zero columns: row is cleared without events
        set_register(CFG_COLUMN_COUNT, 8'd0);
        send_row(4'd3, 16'h0000);
        send_row(4'd7, 16'h1234);
        settle();
        // oversized count saturates at 16
        set_register(CFG_COLUMN_COUNT, 8'hFF);
        send_row(4'd3, 16'h0000);
        send_row(4'd2, 16'h8001);
        settle();
        set_register(CFG_COLUMN_COUNT, 8'd1);
        set_register(CFG_INDEX_BASE, 8'd0);
        send_row(4'd5, 16'hFFFE);
        send_row(4'd5, 16'hFFFF);
        settle();
        // upper columns stored as released while narrow
        set_register(CFG_COLUMN_COUNT, 8'd4);
        send_row(4'd6, 16'h0000);
        settle();
        set_register(CFG_COLUMN_COUNT, 8'd16);
        send_row(4'd6, 16'h0000);
        settle();
        set_register(CFG_ROW_COUNT, 8'd1);
        send_row(4'd1, 16'h0000);
        send_row(4'd0, 16'hAAAA);
        settle();
        set_register(CFG_ROW_COUNT, 8'd0);
        send_row(4'd0, 16'h0000);
        settle();
        set_register(CFG_ROW_COUNT, 8'hEF);
        send_row(4'd15, 16'h0000);
        send_row(4'd14, 16'h0000);
        settle();

        for (int blk = 0; blk < 6; blk++) begin
            if (blk == 2) begin
                send_idle = 81;
                recv_idle = 20;
            end else if (blk == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            idx_base = (base_set[blk] == 37) ? int'($urandom_range(255)) : base_set[blk];
            set_register(CFG_COLUMN_COUNT, 8'(col_set[blk]));
            set_register(CFG_ROW_COUNT, 8'(row_set[blk]));
            set_register(CFG_INDEX_BASE, 8'(idx_base));
            set_register(CFG_EVENTS_ENABLE, 8'd1);
            scan_rows(16);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
